// File: rtl/assert_macros.svh
// assertion helper macros used by tlfs_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while the active-low reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// File: rtl/tlfs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlfs_pkg
// shared types and constants for the three-level feedback scheduler
// ---------------------------------------------------------------------------
package tlfs_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int QUANTUM_W  = 4;
    localparam int SLICE_W    = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LOW  = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // result of one transaction as the back end emits it
    typedef struct packed {
        logic                served_valid;
        logic                job_finished;
        logic                queue_full;
        logic [SLICE_W-1:0]  slice_number;
    } t_result_flags;

endpackage

// File: rtl/tlfs_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlfs_front
// input skid register and opcode classification into a short command queue
// ---------------------------------------------------------------------------
module tlfs_front #(
    parameter int ID_BITS      = 8,
    parameter int SERVICE_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_opcode,
    input  logic [ID_BITS-1:0]      i_job_id,
    input  logic [1:0]              i_job_level,
    input  logic [SERVICE_BITS-1:0] i_job_service,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_is_tick,
    output logic [ID_BITS-1:0]      o_job_id,
    output logic [1:0]              o_job_level,
    output logic [SERVICE_BITS-1:0] o_job_service
);

    localparam int W = 1 + ID_BITS + 2 + SERVICE_BITS;

    logic [W-1:0] r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;
    logic [1:0]   lvl_clamped;

    // level three maps to the lowest queue
    assign lvl_clamped = (i_job_level == 2'd3) ? 2'd2 : i_job_level;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    assign {o_is_tick, o_job_id, o_job_level, o_job_service} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {i_opcode == tlfs_pkg::OP_TICK, i_job_id, lvl_clamped, i_job_service};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/tlfs_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlfs_back
// level queues, running job and slice accounting; while the output is not stalled, one command per cycle
// ---------------------------------------------------------------------------
module tlfs_back #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ID_BITS      = 8,
    parameter int SERVICE_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_is_tick,
    input  logic [ID_BITS-1:0]                   i_job_id,
    input  logic [1:0]                           i_job_level,
    input  logic [SERVICE_BITS-1:0]              i_job_service,
    input  logic [tlfs_pkg::QUANTUM_W-1:0]       i_q_high,
    input  logic [tlfs_pkg::QUANTUM_W-1:0]       i_q_mid,
    input  logic [tlfs_pkg::QUANTUM_W-1:0]       i_q_low,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output tlfs_pkg::t_result_flags              o_flags,
    output logic [ID_BITS-1:0]                   o_served_id
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + SERVICE_BITS;

    logic [EW-1:0] r_mem0 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem1 [QUEUE_DEPTH];
    logic [EW-1:0] r_mem2 [QUEUE_DEPTH];
    logic [AW-1:0] r_head [3];
    logic [AW-1:0] r_tail [3];
    logic [CW-1:0] r_cnt  [3];

    logic [ID_BITS-1:0]      r_run_id;
    logic [SERVICE_BITS-1:0] r_run_svc;
    logic [1:0]              r_run_lvl;
    logic [tlfs_pkg::QUANTUM_W-1:0] r_run_used;
    logic                    r_active, r_move;
    logic [tlfs_pkg::SLICE_W-1:0] r_time;
    logic                    r_out_v;
    tlfs_pkg::t_result_flags r_flags;
    logic [ID_BITS-1:0]      r_sid;

    // combinational next-state view
    logic [CW-1:0] cnt_a [3];
    logic          push_en, push_ok, take, step;
    logic [1:0]    push_lvl, sel_lvl;
    logic [ID_BITS-1:0]      push_id, sel_id, cur_id;
    logic [SERVICE_BITS-1:0] push_svc, sel_svc, cur_svc, svc_dec;
    logic [EW-1:0]           head_ent;
    logic [1:0]              cur_lvl;
    logic [tlfs_pkg::QUANTUM_W-1:0] qsel, qeff, used_n;
    logic                    full_flag, fin, demote, cur_active;
    logic [tlfs_pkg::SLICE_W-1:0] time_n;

    assign o_ready = !r_out_v || i_ready;
    assign step    = i_valid && o_ready;
    assign o_valid = r_out_v;
    assign o_flags = r_flags;
    assign o_served_id = r_sid;

    always_comb begin
        push_en  = 1'b0;
        push_lvl = i_job_level;
        push_id  = i_job_id;
        push_svc = i_job_service;
        if (i_is_tick) begin
            push_en  = r_move;
            push_lvl = (r_run_lvl == 2'd2) ? 2'd2 : r_run_lvl + 2'd1;
            push_id  = r_run_id;
            push_svc = r_run_svc;
        end else begin
            push_en = 1'b1;
        end
        push_ok   = push_en && (r_cnt[push_lvl] != CW'(QUEUE_DEPTH));
        full_flag = push_en && !push_ok;
        for (int l = 0; l < 3; l++) begin
            cnt_a[l] = r_cnt[l] + ((push_ok && push_lvl == 2'(l)) ? CW'(1) : CW'(0));
        end
        // selection sees the demoted job already queued
        take    = i_is_tick && !r_active;
        sel_lvl = (cnt_a[0] != '0) ? 2'd0 : (cnt_a[1] != '0) ? 2'd1 : 2'd2;
        if (take && cnt_a[sel_lvl] == '0) take = 1'b0;
        case (sel_lvl)
            2'd0:    head_ent = r_mem0[r_head[0]];
            2'd1:    head_ent = r_mem1[r_head[1]];
            default: head_ent = r_mem2[r_head[2]];
        endcase
        // a queue that was empty before this push hands over the pushed entry
        if (r_cnt[sel_lvl] == '0) head_ent = {push_id, push_svc};
        {sel_id, sel_svc} = head_ent;
        cur_active = r_active || take;
        cur_id  = take ? sel_id  : r_run_id;
        cur_svc = take ? sel_svc : r_run_svc;
        cur_lvl = take ? sel_lvl : r_run_lvl;
        used_n  = (take ? '0 : r_run_used) + 1'b1;
        case (cur_lvl)
            2'd0:    qsel = i_q_high;
            2'd1:    qsel = i_q_mid;
            default: qsel = i_q_low;
        endcase
        qeff    = (qsel == '0) ? 4'd1 : qsel;
        svc_dec = (cur_svc != '0) ? cur_svc - 1'b1 : cur_svc;
        fin     = cur_active && (svc_dec == '0);
        demote  = cur_active && !fin && (used_n >= qeff);
        time_n  = r_time + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (step && push_ok) begin
            case (push_lvl)
                2'd0:    r_mem0[r_tail[0]] <= {push_id, push_svc};
                2'd1:    r_mem1[r_tail[1]] <= {push_id, push_svc};
                default: r_mem2[r_tail[2]] <= {push_id, push_svc};
            endcase
        end
        if (step) begin
            r_flags.queue_full   <= full_flag;
            r_flags.served_valid <= i_is_tick && cur_active;
            r_flags.job_finished <= i_is_tick && fin;
            r_flags.slice_number <= i_is_tick ? time_n : '0;
            r_sid <= (i_is_tick && cur_active) ? cur_id : '0;
        end
        if (!i_rst_n) begin
            for (int l = 0; l < 3; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_cnt[l]  <= '0;
            end
            r_run_id   <= '0;
            r_run_svc  <= '0;
            r_run_lvl  <= '0;
            r_run_used <= '0;
            r_active   <= 1'b0;
            r_move     <= 1'b0;
            r_time     <= '0;
            r_out_v    <= 1'b0;
        end else begin
            if (o_ready) r_out_v <= i_valid;
            if (step) begin
                for (int l = 0; l < 3; l++) begin
                    r_cnt[l] <= cnt_a[l] - ((take && sel_lvl == 2'(l)) ? CW'(1) : CW'(0));
                    if (push_ok && push_lvl == 2'(l)) begin
                        r_tail[l] <= (r_tail[l] == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail[l] + 1'b1;
                    end
                    if (take && sel_lvl == 2'(l)) begin
                        r_head[l] <= (r_head[l] == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head[l] + 1'b1;
                    end
                end
                if (i_is_tick) begin
                    r_time     <= time_n;
                    r_move     <= demote;
                    r_active   <= cur_active && !fin && !demote;
                    r_run_id   <= cur_id;
                    r_run_svc  <= cur_active ? svc_dec : cur_svc;
                    r_run_lvl  <= cur_lvl;
                    r_run_used <= cur_active ? used_n : r_run_used;
                end
            end
        end
    end

endmodule

// File: rtl/three_level_feedback_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_level_feedback_scheduler_unit
// three-level feedback job scheduler with quantum demotion
// ---------------------------------------------------------------------------
// channel   | dir | handshake              | payload
// s_axis    | in  | tvalid/tready          | tdata: job_id, job_level, job_service; tuser: opcode
// m_axis    | out | tvalid/tready          | tdata: served_id, slice_number; tuser: flags
// cfg       | in  | i_cfg_we               | i_cfg_idx, i_cfg_data (4 bit quantum)
// one transaction per cycle sustained while m_axis_tready is high; the back end
// updates queues and the running job together, and a result passes through the
// command queue and then the output register. reset is synchronous and needs no
// clearing pass. either side may stall independently through the two-entry queue.
// ---------------------------------------------------------------------------
module three_level_feedback_scheduler_unit #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int ID_BITS      = 8,
    parameter int SERVICE_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // job_id, job_level[1:0], job_service, zero fill
    input  logic [((ID_BITS+2+SERVICE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // served_id, slice_number[15:0], zero fill
    output logic [((ID_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // served_valid, job_finished, queue_full
    output logic [2:0] m_axis_tuser,
    input  logic       i_cfg_we,
    input  logic [tlfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlfs_pkg::QUANTUM_W-1:0] i_cfg_data
);

    localparam int OW = ((ID_BITS + 16 + 7) / 8) * 8;

    logic [tlfs_pkg::QUANTUM_W-1:0] r_q_high, r_q_mid, r_q_low;
    logic f_valid, f_ready, f_tick;
    logic [ID_BITS-1:0] f_id, sid;
    logic [1:0] f_lvl;
    logic [SERVICE_BITS-1:0] f_svc;
    tlfs_pkg::t_result_flags flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_high <= 4'd1;
            r_q_mid  <= 4'd2;
            r_q_low  <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlfs_pkg::CFG_QUANTUM_HIGH: r_q_high <= i_cfg_data;
                tlfs_pkg::CFG_QUANTUM_MID:  r_q_mid  <= i_cfg_data;
                tlfs_pkg::CFG_QUANTUM_LOW:  r_q_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlfs_front #(.ID_BITS(ID_BITS), .SERVICE_BITS(SERVICE_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_opcode(s_axis_tuser),
        .i_job_id(s_axis_tdata[ID_BITS-1:0]),
        .i_job_level(s_axis_tdata[ID_BITS+1:ID_BITS]),
        .i_job_service(s_axis_tdata[ID_BITS+2+SERVICE_BITS-1:ID_BITS+2]),
        .o_valid(f_valid), .i_ready(f_ready), .o_is_tick(f_tick),
        .o_job_id(f_id), .o_job_level(f_lvl), .o_job_service(f_svc)
    );

    tlfs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS),
                .SERVICE_BITS(SERVICE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_is_tick(f_tick),
        .i_job_id(f_id), .i_job_level(f_lvl), .i_job_service(f_svc),
        .i_q_high(r_q_high), .i_q_mid(r_q_mid), .i_q_low(r_q_low),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_flags(flags), .o_served_id(sid)
    );

    assign m_axis_tdata = OW'({flags.slice_number, sid});
    assign m_axis_tuser = {flags.queue_full, flags.job_finished, flags.served_valid};

endmodule

// File: rtl/tlfs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlfs_checker
// port-level checks for the scheduler
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module tlfs_checker #(
    parameter int ID_BITS = 8
) (
    input logic                                               i_clk,
    input logic                                               i_rst_n,
    input logic                                               m_axis_tvalid,
    input logic                                               m_axis_tready,
    input logic [((ID_BITS+tlfs_pkg::SLICE_W+7)/8)*8-1:0]     m_axis_tdata,
    input logic [2:0]                                         m_axis_tuser
);
    `CHK_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `CHK_ASSERT(a_fin_served, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "finished without a served job")
    `CHK_ASSERT(a_idle_id, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[ID_BITS-1:0] == '0, "idle slice carries an id")
endmodule

bind three_level_feedback_scheduler_unit tlfs_checker #(.ID_BITS(ID_BITS)) u_tlfs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
